[design/msi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msi_pkg
// Shared types and codes for the multimode sample interpolator.
// ----------------------------------------------------------------------------
package msi_pkg;

  localparam int VALUE_BITS = 27;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] action_t;
  typedef logic [2:0] op_t;

  // interpolation mode register codes
  localparam mode_t MODE_LINEAR = 2'd0;
  localparam mode_t MODE_CUBIC  = 2'd1;
  localparam mode_t MODE_CATROM = 2'd2;
  localparam mode_t MODE_NONE   = 2'd3;

  // dimension selector codes
  localparam action_t ACT_1D = 2'd0;
  localparam action_t ACT_2D = 2'd1;
  localparam action_t ACT_3D = 2'd2;

  // internal operation codes carried down the pipeline
  localparam op_t OP_ZERO   = 3'd0;
  localparam op_t OP_LIN    = 3'd1;
  localparam op_t OP_CUBIC  = 3'd2;
  localparam op_t OP_BILIN  = 3'd3;
  localparam op_t OP_TRILIN = 3'd4;

endpackage
`default_nettype wire

[design/msi_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msi_in_if
// Input channel: valid/ready handshake with samples, fractions and selector.
// ----------------------------------------------------------------------------
interface msi_in_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
);
  import msi_pkg::*;

  logic                          valid;
  logic                          ready;
  action_t                       action;
  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [SAMPLE_BITS-1:0] s1;
  logic signed [SAMPLE_BITS-1:0] s2;
  logic signed [SAMPLE_BITS-1:0] s3;
  logic signed [SAMPLE_BITS-1:0] s4;
  logic signed [SAMPLE_BITS-1:0] s5;
  logic signed [SAMPLE_BITS-1:0] s6;
  logic signed [SAMPLE_BITS-1:0] s7;
  logic [FRAC_BITS-1:0]          fx;
  logic [FRAC_BITS-1:0]          fy;
  logic [FRAC_BITS-1:0]          fz;

  modport source (
    output valid, action, s0, s1, s2, s3, s4, s5, s6, s7, fx, fy, fz,
    input  ready
  );

  modport sink (
    input  valid, action, s0, s1, s2, s3, s4, s5, s6, s7, fx, fy, fz,
    output ready
  );

endinterface
`default_nettype wire

[design/msi_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msi_out_if
// Output channel: valid/ready handshake with the interpolated value.
// ----------------------------------------------------------------------------
interface msi_out_if;
  import msi_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (
    output valid, value,
    input  ready
  );

  modport sink (
    input  valid, value,
    output ready
  );

endinterface
`default_nettype wire

[design/multimode_sample_interpolator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multimode_sample_interpolator
// Linear, cubic and Catmull-Rom interpolation in one dimension, bilinear and
// trilinear interpolation in two and three, as a ten-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per item: action, samples s0..s7 and the
//   fractions fx, fy, fz. out_ch returns one transaction with the floored,
//   saturated value for every accepted item, in order.
//   cfg_wr_en / cfg_wr_data write the interpolation mode; write it only while
//   the pipeline is empty.
// Timing:
//   One item is accepted every cycle unless the pipeline is full and out_ch
//   is stalled; the multiply-add chain of the cubic (three Horner steps) and
//   the x/y/z lerp tree set the ten-stage depth.
// Reset:
//   rst clears every stage valid bit and sets the mode to Catmull-Rom.
// Backpressure:
//   each stage holds while it is full and the next one cannot take its data,
//   so empty stages keep filling while out_ch is stalled; in_ch.ready drops
//   only once the whole pipeline is full. Nothing is lost or duplicated.
// ----------------------------------------------------------------------------
module multimode_sample_interpolator #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  msi_pkg::mode_t    cfg_wr_data,
  msi_in_if.sink            in_ch,
  msi_out_if.source         out_ch
);
  import msi_pkg::*;

  localparam int NSTG = 10;
  localparam int F    = FRAC_BITS;
  localparam int DW   = SAMPLE_BITS + 1;          // lane difference
  localparam int CW   = SAMPLE_BITS + 4;          // cubic coefficients
  localparam int LW   = SAMPLE_BITS + F + 1;      // x lerp
  localparam int DYW  = LW + 1;                   // y difference
  localparam int YL   = DYW / 2;
  localparam int YH   = DYW - YL;
  localparam int MW   = SAMPLE_BITS + 2 * F + 1;  // y lerp
  localparam int DZW  = MW + 1;                   // z difference
  localparam int ZL   = DZW / 2;
  localparam int ZH   = DZW - ZL;
  localparam int RW   = SAMPLE_BITS + 3 * F + 1;  // z lerp
  localparam int Y1W  = CW + F + 1;               // horner terms
  localparam int A1L  = Y1W / 2;
  localparam int A1H  = Y1W - A1L;
  localparam int Y2W  = Y1W + F + 1;
  localparam int A2L  = Y2W / 2;
  localparam int A2H  = Y2W - A2L;
  localparam int Y3W  = Y2W + F + 1;
  localparam int SATW = Y3W;

  localparam logic signed [SATW-1:0] SAT_HI =
    SATW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SATW-1:0] SAT_LO = ~SAT_HI;

  function automatic value_t sat(input logic signed [SATW-1:0] v);
    value_t r;
    if (v > SAT_HI) begin
      r = value_t'(SAT_HI[VALUE_BITS-1:0]);
    end else if (v < SAT_LO) begin
      r = value_t'(SAT_LO[VALUE_BITS-1:0]);
    end else begin
      r = value_t'(v[VALUE_BITS-1:0]);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // mode register and pipeline flow control
  // --------------------------------------------------------------------------
  mode_t             interp_mode;
  logic [NSTG:1]     vld;
  logic [NSTG+1:1]   adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= MODE_CATROM;
    end else if (cfg_wr_en) begin
      interp_mode <= cfg_wr_data;
    end
  end

  assign adv[NSTG+1] = out_ch.ready;

  // a stage loads when it is empty or its content moves on
  for (genvar k = 1; k <= NSTG; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ch.ready  = adv[1];
  assign out_ch.valid = vld[NSTG];

  // --------------------------------------------------------------------------
  // stage 1: decode, coefficients and lane differences
  // --------------------------------------------------------------------------
  op_t                     op_next;
  logic signed [CW-1:0]    p0, p1, p2, p3;
  logic signed [CW-1:0]    c0_next, c1_next, c2_next, c3_next;
  logic signed [SAMPLE_BITS-1:0] base0_next;
  logic signed [DW-1:0]    diff0_next;

  always_comb begin
    p0 = CW'(in_ch.s0);
    p1 = CW'(in_ch.s1);
    p2 = CW'(in_ch.s2);
    p3 = CW'(in_ch.s3);

    unique case (in_ch.action)
      ACT_1D: begin
        unique case (interp_mode)
          MODE_LINEAR: op_next = OP_LIN;
          MODE_CUBIC:  op_next = OP_CUBIC;
          MODE_CATROM: op_next = OP_CUBIC;
          default:     op_next = OP_ZERO;
        endcase
      end
      ACT_2D:  op_next = (interp_mode == MODE_LINEAR) ? OP_BILIN : OP_ZERO;
      ACT_3D:  op_next = (interp_mode == MODE_LINEAR) ? OP_TRILIN : OP_ZERO;
      default: op_next = OP_ZERO;
    endcase

    // both cubic forms kept at twice their scale, removed by the final shift
    if (interp_mode == MODE_CUBIC) begin
      c0_next = (p3 - p2 - p0 + p1) <<< 1;
      c1_next = ((p0 <<< 1) - (p1 <<< 1) + p2 - p3) <<< 1;
      c2_next = (p2 - p0) <<< 1;
    end else begin
      c0_next = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
      c1_next = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
      c2_next = p2 - p0;
    end
    c3_next = p1 <<< 1;

    // 1D linear runs lane 0 between s1 and s2
    if (op_next == OP_LIN) begin
      base0_next = in_ch.s1;
      diff0_next = DW'(in_ch.s2) - DW'(in_ch.s1);
    end else begin
      base0_next = in_ch.s0;
      diff0_next = DW'(in_ch.s1) - DW'(in_ch.s0);
    end
  end

  op_t                           op_s1;
  logic [F-1:0]                  fx_s1, fy_s1, fz_s1;
  logic signed [SAMPLE_BITS-1:0] base0_s1, base1_s1, base2_s1, base3_s1;
  logic signed [DW-1:0]          diff0_s1, diff1_s1, diff2_s1, diff3_s1;
  logic signed [CW-1:0]          c0_s1, c1_s1, c2_s1, c3_s1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op_s1    <= op_next;
      fx_s1    <= in_ch.fx;
      fy_s1    <= in_ch.fy;
      fz_s1    <= in_ch.fz;
      base0_s1 <= base0_next;
      base1_s1 <= in_ch.s2;
      base2_s1 <= in_ch.s4;
      base3_s1 <= in_ch.s6;
      diff0_s1 <= diff0_next;
      diff1_s1 <= DW'(in_ch.s3) - DW'(in_ch.s2);
      diff2_s1 <= DW'(in_ch.s5) - DW'(in_ch.s4);
      diff3_s1 <= DW'(in_ch.s7) - DW'(in_ch.s6);
      c0_s1    <= c0_next;
      c1_s1    <= c1_next;
      c2_s1    <= c2_next;
      c3_s1    <= c3_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: x products of the four lanes and the first horner product
  // --------------------------------------------------------------------------
  logic signed [F:0]             fxs_s1;
  op_t                           op_s2;
  logic [F-1:0]                  fx_s2, fy_s2, fz_s2;
  logic signed [SAMPLE_BITS-1:0] base0_s2, base1_s2, base2_s2, base3_s2;
  logic signed [LW-1:0]          pd0_s2, pd1_s2, pd2_s2, pd3_s2;
  logic signed [Y1W-1:0]         hp_s2;
  logic signed [CW-1:0]          c1_s2, c2_s2, c3_s2;

  assign fxs_s1 = $signed({1'b0, fx_s1});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op_s2    <= op_s1;
      fx_s2    <= fx_s1;
      fy_s2    <= fy_s1;
      fz_s2    <= fz_s1;
      base0_s2 <= base0_s1;
      base1_s2 <= base1_s1;
      base2_s2 <= base2_s1;
      base3_s2 <= base3_s1;
      pd0_s2   <= LW'(diff0_s1) * LW'(fxs_s1);
      pd1_s2   <= LW'(diff1_s1) * LW'(fxs_s1);
      pd2_s2   <= LW'(diff2_s1) * LW'(fxs_s1);
      pd3_s2   <= LW'(diff3_s1) * LW'(fxs_s1);
      hp_s2    <= Y1W'(c0_s1) * Y1W'(fxs_s1);
      c1_s2    <= c1_s1;
      c2_s2    <= c2_s1;
      c3_s2    <= c3_s1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: x lerps and first horner sum
  // --------------------------------------------------------------------------
  op_t                   op_s3;
  logic [F-1:0]          fx_s3, fy_s3, fz_s3;
  logic signed [LW-1:0]  l0_s3, l1_s3, l2_s3, l3_s3;
  logic signed [Y1W-1:0] y1_s3;
  logic signed [CW-1:0]  c2_s3, c3_s3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      op_s3 <= op_s2;
      fx_s3 <= fx_s2;
      fy_s3 <= fy_s2;
      fz_s3 <= fz_s2;
      l0_s3 <= (LW'(base0_s2) <<< F) + pd0_s2;
      l1_s3 <= (LW'(base1_s2) <<< F) + pd1_s2;
      l2_s3 <= (LW'(base2_s2) <<< F) + pd2_s2;
      l3_s3 <= (LW'(base3_s2) <<< F) + pd3_s2;
      y1_s3 <= hp_s2 + (Y1W'(c1_s2) <<< F);
      c2_s3 <= c2_s2;
      c3_s3 <= c3_s2;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: 1D linear result, y differences, split product y1 * fx
  // --------------------------------------------------------------------------
  logic signed [F:0]       fxs_s3;
  op_t                     op_s4;
  logic [F-1:0]            fx_s4, fy_s4, fz_s4;
  logic signed [LW-1:0]    l0_s4, l2_s4;
  logic signed [DYW-1:0]   dya_s4, dyb_s4;
  logic [A1L+F-1:0]        h1l_s4;
  logic signed [A1H+F:0]   h1h_s4;
  logic signed [CW-1:0]    c2_s4, c3_s4;
  value_t                  res_s4;

  assign fxs_s3 = $signed({1'b0, fx_s3});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      op_s4  <= op_s3;
      fx_s4  <= fx_s3;
      fy_s4  <= fy_s3;
      fz_s4  <= fz_s3;
      l0_s4  <= l0_s3;
      l2_s4  <= l2_s3;
      dya_s4 <= DYW'(l1_s3) - DYW'(l0_s3);
      dyb_s4 <= DYW'(l3_s3) - DYW'(l2_s3);
      h1l_s4 <= (A1L+F)'(y1_s3[A1L-1:0]) * (A1L+F)'(fx_s3);
      h1h_s4 <= (A1H+F+1)'($signed(y1_s3[Y1W-1:A1L])) * (A1H+F+1)'(fxs_s3);
      c2_s4  <= c2_s3;
      c3_s4  <= c3_s3;
      res_s4 <= (op_s3 == OP_LIN) ? sat(SATW'(l0_s3 >>> F)) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: split products of the y differences, second horner sum
  // --------------------------------------------------------------------------
  logic signed [F:0]     fys_s4;
  op_t                   op_s5;
  logic [F-1:0]          fx_s5, fz_s5;
  logic signed [LW-1:0]  l0_s5, l2_s5;
  logic [YL+F-1:0]       pal_s5, pbl_s5;
  logic signed [YH+F:0]  pah_s5, pbh_s5;
  logic signed [Y2W-1:0] y2_s5;
  logic signed [CW-1:0]  c3_s5;
  value_t                res_s5;

  assign fys_s4 = $signed({1'b0, fy_s4});

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      op_s5  <= op_s4;
      fx_s5  <= fx_s4;
      fz_s5  <= fz_s4;
      l0_s5  <= l0_s4;
      l2_s5  <= l2_s4;
      pal_s5 <= (YL+F)'(dya_s4[YL-1:0]) * (YL+F)'(fy_s4);
      pah_s5 <= (YH+F+1)'($signed(dya_s4[DYW-1:YL])) * (YH+F+1)'(fys_s4);
      pbl_s5 <= (YL+F)'(dyb_s4[YL-1:0]) * (YL+F)'(fy_s4);
      pbh_s5 <= (YH+F+1)'($signed(dyb_s4[DYW-1:YL])) * (YH+F+1)'(fys_s4);
      y2_s5  <= (Y2W'(h1h_s4) <<< A1L) + Y2W'({1'b0, h1l_s4})
                + (Y2W'(c2_s4) <<< (2 * F));
      c3_s5  <= c3_s4;
      res_s5 <= res_s4;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: y lerps, split product y2 * fx
  // --------------------------------------------------------------------------
  logic signed [F:0]     fxs_s5;
  op_t                   op_s6;
  logic [F-1:0]          fz_s6;
  logic signed [MW-1:0]  m0_s6, m1_s6;
  logic [A2L+F-1:0]      h2l_s6;
  logic signed [A2H+F:0] h2h_s6;
  logic signed [CW-1:0]  c3_s6;
  value_t                res_s6;

  assign fxs_s5 = $signed({1'b0, fx_s5});

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      op_s6  <= op_s5;
      fz_s6  <= fz_s5;
      m0_s6  <= (MW'(l0_s5) <<< F) + (MW'(pah_s5) <<< YL) + MW'({1'b0, pal_s5});
      m1_s6  <= (MW'(l2_s5) <<< F) + (MW'(pbh_s5) <<< YL) + MW'({1'b0, pbl_s5});
      h2l_s6 <= (A2L+F)'(y2_s5[A2L-1:0]) * (A2L+F)'(fx_s5);
      h2h_s6 <= (A2H+F+1)'($signed(y2_s5[Y2W-1:A2L])) * (A2H+F+1)'(fxs_s5);
      c3_s6  <= c3_s5;
      res_s6 <= res_s5;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: bilinear result, z difference, last horner sum
  // --------------------------------------------------------------------------
  op_t                   op_s7;
  logic [F-1:0]          fz_s7;
  logic signed [MW-1:0]  m0_s7;
  logic signed [DZW-1:0] dz_s7;
  logic signed [Y3W-1:0] y3_s7;
  value_t                res_s7;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      op_s7  <= op_s6;
      fz_s7  <= fz_s6;
      m0_s7  <= m0_s6;
      dz_s7  <= DZW'(m1_s6) - DZW'(m0_s6);
      y3_s7  <= (Y3W'(h2h_s6) <<< A2L) + Y3W'({1'b0, h2l_s6})
                + (Y3W'(c3_s6) <<< (3 * F));
      res_s7 <= (op_s6 == OP_BILIN) ? sat(SATW'(m0_s6 >>> (2 * F))) : res_s6;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: cubic result, split product dz * fz
  // --------------------------------------------------------------------------
  logic signed [F:0]     fzs_s7;
  op_t                   op_s8;
  logic signed [MW-1:0]  m0_s8;
  logic [ZL+F-1:0]       pzl_s8;
  logic signed [ZH+F:0]  pzh_s8;
  value_t                res_s8;

  assign fzs_s7 = $signed({1'b0, fz_s7});

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      op_s8  <= op_s7;
      m0_s8  <= m0_s7;
      pzl_s8 <= (ZL+F)'(dz_s7[ZL-1:0]) * (ZL+F)'(fz_s7);
      pzh_s8 <= (ZH+F+1)'($signed(dz_s7[DZW-1:ZL])) * (ZH+F+1)'(fzs_s7);
      res_s8 <= (op_s7 == OP_CUBIC) ? sat(SATW'(y3_s7 >>> (3 * F + 1))) : res_s7;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: z lerp
  // --------------------------------------------------------------------------
  op_t                  op_s9;
  logic signed [RW-1:0] r_s9;
  value_t               res_s9;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      op_s9  <= op_s8;
      r_s9   <= (RW'(m0_s8) <<< F) + (RW'(pzh_s8) <<< ZL) + RW'({1'b0, pzl_s8});
      res_s9 <= res_s8;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: trilinear result, output register
  // --------------------------------------------------------------------------
  value_t res_s10;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      res_s10 <= (op_s9 == OP_TRILIN) ? sat(SATW'(r_s9 >>> (3 * F))) : res_s9;
    end
  end

  assign out_ch.value = res_s10;

endmodule
`default_nettype wire
